FILE: rtl/ymfr_pkg.sv
package ymfr_pkg;

  // Result kinds (tuser on the master side)
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_ERASE = 2'd1;
  localparam logic [1:0] KIND_RESP  = 2'd2;
  localparam logic [1:0] KIND_RSVD  = 2'd3;

  // Response codes
  localparam logic [1:0] RESP_ACK = 2'd0;
  localparam logic [1:0] RESP_NAK = 2'd1;
  localparam logic [1:0] RESP_C   = 2'd2;
  localparam logic [1:0] RESP_END = 2'd3;

  // Frame types
  localparam logic [7:0] FT_SOH = 8'h01;
  localparam logic [7:0] FT_STX = 8'h02;
  localparam logic [7:0] FT_EOT = 8'h04;
  localparam logic [7:0] FT_UPD = 8'h31;

  // Configuration register indexes
  localparam logic [1:0] CFG_IMAGE_BASE  = 2'd0;
  localparam logic [1:0] CFG_ERASE_PAGES = 2'd1;
  localparam logic [1:0] CFG_GAP_TICKS   = 2'd2;

  localparam logic [31:0] IMAGE_BASE_RST  = 32'd0;
  localparam logic [7:0]  ERASE_PAGES_RST = 8'd1;
  localparam logic [15:0] GAP_TICKS_RST   = 16'd1000;

  localparam int unsigned SOH_BLOCK = 128;
  localparam int unsigned STX_BLOCK = 1024;
  localparam int unsigned HDR_BYTES = 3;

  localparam int unsigned QDEPTH = 4;

  // Job handed from the front to the back; the back expands it into beats
  typedef enum logic [2:0] {
    JOB_WRITE,    // one flash byte write
    JOB_START,    // erase, ACK, C
    JOB_ACK,      // ACK
    JOB_NAK,      // NAK
    JOB_ACK_C,    // ACK, C
    JOB_ACK_END   // ACK, END
  } job_op_e;

  typedef struct packed {
    job_op_e     op;
    logic [31:0] addr;
    logic [7:0]  data;      // byte to write, or page count for erase
    logic [1:0]  progress;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } push_t;

endpackage

FILE: rtl/ymfr_front.sv
module ymfr_front import ymfr_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        acc_i,
  input  logic        op_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output push_t       push_o
);

  localparam int unsigned PW = $clog2(FRAME_BYTES + 1);

  localparam logic [1:0] PS_WAIT  = 2'd0;
  localparam logic [1:0] PS_DATA  = 2'd1;
  localparam logic [1:0] PS_EOT   = 2'd2;
  localparam logic [1:0] PS_FINAL = 2'd3;

  logic [31:0] base_q;
  logic [7:0]  pages_q;
  logic [15:0] gap_q;

  logic [1:0]    pst_q, pst_d;
  logic [31:0]   wa_q, wa_d;
  logic [1:0]    prog_q, prog_d;
  logic [7:0]    fkind_q, fkind_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [15:0]   cnt_q, cnt_d;
  logic          run_q, run_d;

  logic [PW-1:0] off;
  logic [15:0]   cnt_inc;
  push_t         push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= IMAGE_BASE_RST;
      pages_q <= ERASE_PAGES_RST;
      gap_q   <= GAP_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_BASE:  base_q  <= cfg_data_i;
        CFG_ERASE_PAGES: pages_q <= cfg_data_i[7:0];
        CFG_GAP_TICKS:   gap_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pst_d   = pst_q;
    wa_d    = wa_q;
    prog_d  = prog_q;
    fkind_d = fkind_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    run_d   = run_q;
    off     = pos_q - PW'(HDR_BYTES);
    cnt_inc = cnt_q + 16'd1;
    push    = '0;
    push.job.op = JOB_WRITE;

    if (acc_i) begin
      if (!op_i) begin
        cnt_d = '0;
        run_d = 1'b1;
        if (pos_q < PW'(FRAME_BYTES)) begin
          if (pos_q == '0) begin
            fkind_d = rx_byte_i;
          end
          pos_d = pos_q + PW'(1);
          // payload starts after type, block number and its complement
          if (pst_q == PS_DATA && pos_q >= PW'(HDR_BYTES)) begin
            if ((fkind_q == FT_SOH && off < PW'(SOH_BLOCK)) ||
                (fkind_q == FT_STX && off < PW'(STX_BLOCK))) begin
              push.push     = 1'b1;
              push.job.op   = JOB_WRITE;
              push.job.addr = wa_q + 32'(off);
              push.job.data = rx_byte_i;
            end
          end
        end
      end else if (run_q) begin
        cnt_d = cnt_inc;
        if (cnt_inc >= gap_q) begin
          run_d = 1'b0;
          cnt_d = '0;
          if (pos_q != '0) begin
            pos_d = '0;
            unique case (pst_q)
              PS_WAIT: begin
                if (fkind_q == FT_SOH) begin
                  prog_d        = 2'd1;
                  wa_d          = base_q;
                  pst_d         = PS_DATA;
                  push.push     = 1'b1;
                  push.job.op   = JOB_START;
                  push.job.addr = base_q;
                  push.job.data = pages_q;
                end else if (fkind_q == FT_UPD) begin
                  prog_d = 2'd2;
                end
              end
              PS_DATA: begin
                if (fkind_q == FT_SOH || fkind_q == FT_STX) begin
                  wa_d        = wa_q + ((fkind_q == FT_SOH) ? 32'(SOH_BLOCK) : 32'(STX_BLOCK));
                  push.push   = 1'b1;
                  push.job.op = JOB_ACK;
                end else if (fkind_q == FT_EOT) begin
                  pst_d       = PS_EOT;
                  push.push   = 1'b1;
                  push.job.op = JOB_NAK;
                end else begin
                  pst_d = PS_WAIT;
                end
              end
              PS_EOT: begin
                if (fkind_q == FT_EOT) begin
                  pst_d       = PS_FINAL;
                  push.push   = 1'b1;
                  push.job.op = JOB_ACK_C;
                end
              end
              PS_FINAL: begin
                if (fkind_q == FT_SOH) begin
                  pst_d       = PS_WAIT;
                  prog_d      = 2'd3;
                  push.push   = 1'b1;
                  push.job.op = JOB_ACK_END;
                end
              end
              default: ;
            endcase
          end
        end
      end
    end
    push.job.progress = prog_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pst_q   <= PS_WAIT;
      wa_q    <= '0;
      prog_q  <= '0;
      fkind_q <= '0;
      pos_q   <= '0;
      cnt_q   <= '0;
      run_q   <= 1'b1;
    end else begin
      pst_q   <= pst_d;
      wa_q    <= wa_d;
      prog_q  <= prog_d;
      fkind_q <= fkind_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      run_q   <= run_d;
    end
  end

  assign push_o = push;

endmodule

FILE: rtl/ymfr_queue.sv
module ymfr_queue import ymfr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output job_t  job_o
);

  localparam int unsigned AW = $clog2(QDEPTH);
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  job_t          mem_q [QDEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;
  logic          do_pop;

  assign full_o  = (cnt_q == CW'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rp_q];
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wp_q] <= push_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i.push) begin
        wp_q <= (wp_q == AW'(QDEPTH - 1)) ? '0 : wp_q + AW'(1);
      end
      if (do_pop) begin
        rp_q <= (rp_q == AW'(QDEPTH - 1)) ? '0 : rp_q + AW'(1);
      end
      if (push_i.push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (!push_i.push && do_pop) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/ymfr_back.sv
module ymfr_back import ymfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  job_t        q_job_i,
  output logic        q_pop_o,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] address_o,
  output logic [7:0]  write_byte_o,
  output logic [7:0]  page_count_o,
  output logic [1:0]  response_o,
  output logic [1:0]  progress_o,
  output logic        last_o
);

  job_t       cur_q;
  logic       vld_q;
  logic [1:0] idx_q;
  logic       done;

  always_comb begin
    kind_o       = KIND_RESP;
    address_o    = '0;
    write_byte_o = '0;
    page_count_o = '0;
    response_o   = RESP_ACK;
    last_o       = 1'b1;
    unique case (cur_q.op)
      JOB_WRITE: begin
        kind_o       = KIND_WRITE;
        address_o    = cur_q.addr;
        write_byte_o = cur_q.data;
      end
      JOB_START: begin
        case (idx_q)
          2'd0: begin
            kind_o       = KIND_ERASE;
            address_o    = cur_q.addr;
            page_count_o = cur_q.data;
            last_o       = 1'b0;
          end
          2'd1: last_o = 1'b0;
          default: response_o = RESP_C;
        endcase
      end
      JOB_ACK: ;
      JOB_NAK: response_o = RESP_NAK;
      JOB_ACK_C: begin
        last_o = (idx_q != 2'd0);
        if (idx_q != 2'd0) response_o = RESP_C;
      end
      JOB_ACK_END: begin
        last_o = (idx_q != 2'd0);
        if (idx_q != 2'd0) response_o = RESP_END;
      end
      default: ;
    endcase
  end

  assign progress_o = cur_q.progress;
  assign m_valid_o  = vld_q;
  assign done       = vld_q & m_ready_i & last_o;
  assign q_pop_o    = q_valid_i & (~vld_q | done);

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (q_pop_o) begin
      vld_q <= 1'b1;
      idx_q <= '0;
    end else if (done) begin
      vld_q <= 1'b0;
    end else if (vld_q && m_ready_i) begin
      idx_q <= idx_q + 2'd1;
    end
  end

endmodule

FILE: rtl/ymodem_frame_receiver.sv
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        tuser: operation; tdata: rx_byte
// m_axis    out  m_axis_tvalid/tready        tuser: kind; tdata: result fields; tlast: last
// cfg       in   cfg_valid_i/cfg_ready_o     cfg_index_i, cfg_data_i
//
// One input beat is taken per cycle unless the queue is full; its state update is done
// in that cycle. Results leave at one beat per cycle while m_axis_tready is high; the
// start frame yields three, so the output port sets the sustained rate when many are due.
// A four-entry job queue sits between front and back; s_axis_tready drops only
// when it is full. Reset is asynchronous; no clearing pass is needed.
module ymodem_frame_receiver import ymfr_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [0:0]  s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [31:0] address, [39:32] write_byte,
                                      // [47:40] page_count, [49:48] response,
                                      // [51:50] progress, [55:52] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  push_t       push;
  logic        q_full, q_valid, q_pop;
  job_t        q_job;
  logic        acc;
  logic [31:0] address;
  logic [7:0]  write_byte, page_count;
  logic [1:0]  response, progress;

  assign s_axis_tready = ~q_full;
  assign acc           = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  ymfr_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .op_i        (s_axis_tuser[0]),
    .rx_byte_i   (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push)
  );

  ymfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (q_job)
  );

  ymfr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_job_i      (q_job),
    .q_pop_o      (q_pop),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .kind_o       (m_axis_tuser),
    .address_o    (address),
    .write_byte_o (write_byte),
    .page_count_o (page_count),
    .response_o   (response),
    .progress_o   (progress),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, progress, response, page_count, write_byte, address};

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !push.push) else $error("job pushed into full queue");

  a_kind_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != KIND_RSVD) else $error("reserved result kind");

  a_write_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_WRITE) |-> m_axis_tlast)
    else $error("byte write not last beat");

  a_erase_followed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_ERASE) |-> !m_axis_tlast)
    else $error("erase beat marked last");

endmodule
